>>> hw/rtl/cellular_automaton_3d_assert.svh
// Assertion macros for the checker file of the cellular automaton.
`ifndef CELLULAR_AUTOMATON_3D_ASSERT_SVH
`define CELLULAR_AUTOMATON_3D_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CA3D_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CA3D_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ca3d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ca3d_pkg;

    // Default grid dimensions.
    localparam int X_SIZE_DEF = 64;
    localparam int Y_SIZE_DEF = 32;
    localparam int Z_SIZE_DEF = 32;

    // Fixed widths of the stream and configuration fields.
    localparam int CNT_W       = 5;
    localparam int COORD_W     = 8;
    localparam int ADDR_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    // Reset values of the rule registers.
    localparam logic [CNT_W-1:0] BIRTH_RST   = 5'd9;
    localparam logic [CNT_W-1:0] SURV_LO_RST = 5'd6;
    localparam logic [CNT_W-1:0] SURV_HI_RST = 5'd9;

    typedef enum logic [2:0] {
        ACT_WRITE = 3'd0,
        ACT_READ  = 3'd1,
        ACT_FILL  = 3'd2,
        ACT_SEED  = 3'd3,
        ACT_STEP  = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIRTH   = 2'd0,
        CFG_SURV_LO = 2'd1,
        CFG_SURV_HI = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_STEP_RD,
        ST_STEP_WAIT,
        ST_STEP_WR,
        ST_DONE
    } ctrl_state_t;

    // Memory port control from the sequencer.
    typedef struct packed {
        logic              rd_en;
        logic              rd_bank;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              wr_both;
        logic              wr_bank;
        logic [ADDR_W-1:0] wr_addr;
    } mem_ctl_t;

    // Neighbour accumulator control from the sequencer.
    typedef struct packed {
        logic clear;
        logic acc;
        logic centre;
    } lane_ctl_t;

    // Rule registers.
    typedef struct packed {
        logic [CNT_W-1:0] birth;
        logic [CNT_W-1:0] surv_lo;
        logic [CNT_W-1:0] surv_hi;
    } rule_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/ca3d_grid_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Two banks of cell rows, one row of X cells per word.
module ca3d_grid_mem #(
    parameter int ROWS     = 1024,
    parameter int ROW_BITS = 64
) (
    input  wire logic                 aclk,
    input  wire ca3d_pkg::mem_ctl_t  ctl,
    input  wire logic [ROW_BITS-1:0] wr_data,
    output logic      [ROW_BITS-1:0] rd_data
);

    localparam int ROW_W = $clog2(ROWS);

    logic [ROW_BITS-1:0] bank_a [ROWS];
    logic [ROW_BITS-1:0] bank_b [ROWS];
    logic [ROW_BITS-1:0] a_q_reg;
    logic [ROW_BITS-1:0] b_q_reg;
    logic                sel_reg;

    // Writes go to one bank, or to both during the clearing pass.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en && (ctl.wr_both || !ctl.wr_bank)) begin
            bank_a[ctl.wr_addr[ROW_W-1:0]] <= wr_data;
        end
        if (ctl.wr_en && (ctl.wr_both || ctl.wr_bank)) begin
            bank_b[ctl.wr_addr[ROW_W-1:0]] <= wr_data;
        end
    end

    // Registered read of both banks; the bank is chosen after the register.
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            a_q_reg <= bank_a[ctl.rd_addr[ROW_W-1:0]];
            b_q_reg <= bank_b[ctl.rd_addr[ROW_W-1:0]];
            sel_reg <= ctl.rd_bank;
        end
    end

    assign rd_data = sel_reg ? b_q_reg : a_q_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ca3d_lanes.sv
`timescale 1ns / 1ps
`default_nettype none

// One lane per cell of a row: counts live neighbours over the nine
// neighbouring rows and applies the birth and survival rule.
module ca3d_lanes #(
    parameter int X_SIZE = 64
) (
    input  wire logic               aclk,
    input  wire ca3d_pkg::lane_ctl_t ctl,
    input  wire ca3d_pkg::rule_cfg_t cfg,
    input  wire logic [X_SIZE-1:0]  row_in,
    output logic      [X_SIZE-1:0]  row_out
);

    localparam int CW = ca3d_pkg::CNT_W;

    logic [CW-1:0]     acc_reg [X_SIZE];
    logic [X_SIZE-1:0] centre_reg;

    for (genvar i = 0; i < X_SIZE; i++) begin : g_lane
        logic          left_bit;
        logic          right_bit;
        logic          mid_bit;
        logic [CW-1:0] sum;

        if (i > 0) begin : g_left
            assign left_bit = row_in[i-1];
        end else begin : g_no_left
            assign left_bit = 1'b0;
        end

        if (i < X_SIZE - 1) begin : g_right
            assign right_bit = row_in[i+1];
        end else begin : g_no_right
            assign right_bit = 1'b0;
        end

        // The cell itself is not its own neighbour.
        assign mid_bit = ctl.centre ? 1'b0 : row_in[i];
        assign sum = CW'(left_bit) + CW'(right_bit) + CW'(mid_bit);

        always_ff @(posedge aclk) begin
            if (ctl.clear) begin
                acc_reg[i] <= '0;
            end else if (ctl.acc) begin
                acc_reg[i] <= acc_reg[i] + sum;
            end
            if (ctl.acc && ctl.centre) begin
                centre_reg[i] <= row_in[i];
            end
        end

        // Live cells survive inside the range; dead cells are born at the count.
        assign row_out[i] = centre_reg[i] ?
            ((acc_reg[i] >= cfg.surv_lo) && (acc_reg[i] <= cfg.surv_hi)) :
            (acc_reg[i] == cfg.birth);
    end

endmodule

`default_nettype wire

>>> hw/rtl/ca3d_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: decodes transactions, sweeps rows and holds the result register.
module ca3d_ctrl #(
    parameter int X_SIZE = 64,
    parameter int Y_SIZE = 32,
    parameter int Z_SIZE = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ca3d_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [ca3d_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output ca3d_pkg::mem_ctl_t                       mem_ctl,
    output logic      [X_SIZE-1:0]                   wr_data,
    input  wire logic [X_SIZE-1:0]                   rd_data,
    output ca3d_pkg::lane_ctl_t                      lane_ctl,
    input  wire logic [X_SIZE-1:0]                   row_next
);

    localparam int ROWS  = Y_SIZE * Z_SIZE;
    localparam int ROW_W = $clog2(ROWS);
    localparam int X_W   = $clog2(X_SIZE);
    localparam int CW    = ca3d_pkg::COORD_W;
    localparam int AW    = ca3d_pkg::ADDR_W;
    localparam logic [X_SIZE-1:0] EDGE_ROW = {1'b1, {(X_SIZE-2){1'b0}}, 1'b1};

    ca3d_pkg::ctrl_state_t state_reg, state_next;

    logic [ROW_W-1:0] row_addr_reg, row_addr_next;
    logic [CW-1:0]    row_y_reg, row_y_next;
    logic [CW-1:0]    row_z_reg, row_z_next;
    logic [1:0]       nb_dy_reg, nb_dy_next;
    logic [1:0]       nb_dz_reg, nb_dz_next;
    logic             pend_acc_reg, pend_acc_next;
    logic             pend_ctr_reg, pend_ctr_next;
    logic             bank_reg, bank_next;
    logic [2:0]       act_reg, act_next;
    logic [5:0]       px_reg, px_next;
    logic [4:0]       py_reg, py_next;
    logic [4:0]       pz_reg, pz_next;
    logic             wv_reg, wv_next;
    logic             rv_reg, rv_next;
    logic             m_valid_reg, m_valid_next;
    logic [ca3d_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // Transaction fields.
    logic [2:0] in_act;
    logic [5:0] in_x;
    logic [4:0] in_y;
    logic [4:0] in_z;
    logic       in_wv;
    logic       in_inside;
    logic       accept;
    logic       last_row;
    logic       out_free;

    // Addressing.
    logic [ROW_W-1:0] cell_addr;
    logic [X_W-1:0]   x_idx;
    logic [CW:0]      nb_ty;
    logic [CW:0]      nb_tz;
    logic             nb_inr;
    logic [ROW_W-1:0] nb_addr;
    logic             border_row;
    logic [X_SIZE-1:0] sweep_row;
    logic [X_SIZE-1:0] cell_row;

    assign in_act = s_tdata[2:0];
    assign in_x   = s_tdata[8:3];
    assign in_y   = s_tdata[13:9];
    assign in_z   = s_tdata[18:14];
    assign in_wv  = s_tdata[19];
    assign in_inside = ((CW+1)'(in_x) < (CW+1)'(X_SIZE)) &&
                       ((CW+1)'(in_y) < (CW+1)'(Y_SIZE)) &&
                       ((CW+1)'(in_z) < (CW+1)'(Z_SIZE));

    assign accept   = s_tvalid && s_tready;
    assign last_row = (row_addr_reg == ROW_W'(ROWS - 1));
    assign out_free = !m_valid_reg || m_tready;

    // Row address of the addressed cell.
    assign cell_addr = ROW_W'(24'(py_reg) + 24'(pz_reg) * 24'(Y_SIZE));
    assign x_idx     = X_W'(px_reg);

    // Neighbour row of the current sweep row; rows outside the grid are skipped.
    assign nb_ty  = (CW+1)'(row_y_reg) + (CW+1)'(nb_dy_reg);
    assign nb_tz  = (CW+1)'(row_z_reg) + (CW+1)'(nb_dz_reg);
    assign nb_inr = (nb_ty != '0) && (nb_ty <= (CW+1)'(Y_SIZE)) &&
                    (nb_tz != '0) && (nb_tz <= (CW+1)'(Z_SIZE));
    assign nb_addr = ROW_W'(24'(nb_ty - 1'b1) + 24'(nb_tz - 1'b1) * 24'(Y_SIZE));

    // Row written during a fill or border seeding sweep.
    assign border_row = (row_y_reg == '0) || (row_y_reg == CW'(Y_SIZE - 1)) ||
                        (row_z_reg == '0) || (row_z_reg == CW'(Z_SIZE - 1));

    always_comb begin
        if (act_reg == ca3d_pkg::ACT_FILL) begin
            sweep_row = {X_SIZE{wv_reg}};
        end else if (border_row) begin
            sweep_row = '1;
        end else begin
            sweep_row = EDGE_ROW;
        end
    end

    // Read-modify-write of a single cell.
    always_comb begin
        cell_row = rd_data;
        cell_row[x_idx] = wv_reg;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ca3d_pkg::ST_CLEAR: begin
                if (last_row) begin
                    state_next = ca3d_pkg::ST_IDLE;
                end
            end
            ca3d_pkg::ST_IDLE: begin
                if (accept) begin
                    case (in_act)
                        ca3d_pkg::ACT_WRITE, ca3d_pkg::ACT_READ: begin
                            state_next = in_inside ? ca3d_pkg::ST_CELL_RD : ca3d_pkg::ST_DONE;
                        end
                        ca3d_pkg::ACT_FILL, ca3d_pkg::ACT_SEED: begin
                            state_next = ca3d_pkg::ST_SWEEP;
                        end
                        ca3d_pkg::ACT_STEP: begin
                            state_next = ca3d_pkg::ST_STEP_RD;
                        end
                        default: begin
                            state_next = ca3d_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ca3d_pkg::ST_SWEEP: begin
                if (last_row) begin
                    state_next = ca3d_pkg::ST_DONE;
                end
            end
            ca3d_pkg::ST_CELL_RD: begin
                state_next = ca3d_pkg::ST_CELL_WR;
            end
            ca3d_pkg::ST_CELL_WR: begin
                state_next = ca3d_pkg::ST_DONE;
            end
            ca3d_pkg::ST_STEP_RD: begin
                if ((nb_dy_reg == 2'd2) && (nb_dz_reg == 2'd2)) begin
                    state_next = ca3d_pkg::ST_STEP_WAIT;
                end
            end
            ca3d_pkg::ST_STEP_WAIT: begin
                state_next = ca3d_pkg::ST_STEP_WR;
            end
            ca3d_pkg::ST_STEP_WR: begin
                state_next = last_row ? ca3d_pkg::ST_DONE : ca3d_pkg::ST_STEP_RD;
            end
            ca3d_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ca3d_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ca3d_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs to the memory and the lanes.
    always_comb begin
        s_tready = (state_reg == ca3d_pkg::ST_IDLE);
        mem_ctl  = '0;
        mem_ctl.rd_bank = bank_reg;
        wr_data  = '0;
        lane_ctl.clear  = (state_reg == ca3d_pkg::ST_IDLE) ||
                          (state_reg == ca3d_pkg::ST_STEP_WR);
        lane_ctl.acc    = pend_acc_reg;
        lane_ctl.centre = pend_ctr_reg;
        case (state_reg)
            ca3d_pkg::ST_CLEAR: begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_both = 1'b1;
                mem_ctl.wr_addr = AW'(row_addr_reg);
            end
            ca3d_pkg::ST_SWEEP: begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_bank = bank_reg;
                mem_ctl.wr_addr = AW'(row_addr_reg);
                wr_data         = sweep_row;
            end
            ca3d_pkg::ST_CELL_RD: begin
                mem_ctl.rd_en   = 1'b1;
                mem_ctl.rd_addr = AW'(cell_addr);
            end
            ca3d_pkg::ST_CELL_WR: begin
                mem_ctl.wr_en   = (act_reg == ca3d_pkg::ACT_WRITE);
                mem_ctl.wr_bank = bank_reg;
                mem_ctl.wr_addr = AW'(cell_addr);
                wr_data         = cell_row;
            end
            ca3d_pkg::ST_STEP_RD: begin
                mem_ctl.rd_en   = nb_inr;
                mem_ctl.rd_addr = AW'(nb_addr);
            end
            ca3d_pkg::ST_STEP_WR: begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_bank = !bank_reg;
                mem_ctl.wr_addr = AW'(row_addr_reg);
                wr_data         = row_next;
            end
            default: begin
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        row_addr_next = row_addr_reg;
        row_y_next    = row_y_reg;
        row_z_next    = row_z_reg;
        nb_dy_next    = nb_dy_reg;
        nb_dz_next    = nb_dz_reg;
        bank_next     = bank_reg;
        act_next      = act_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pz_next       = pz_reg;
        wv_next       = wv_reg;
        rv_next       = rv_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        pend_acc_next = (state_reg == ca3d_pkg::ST_STEP_RD) && nb_inr;
        pend_ctr_next = (state_reg == ca3d_pkg::ST_STEP_RD) &&
                        (nb_dy_reg == 2'd1) && (nb_dz_reg == 2'd1);

        // Latch the transaction and restart the row sweep.
        if (accept) begin
            act_next      = in_act;
            px_next       = in_x;
            py_next       = in_y;
            pz_next       = in_z;
            wv_next       = in_wv;
            rv_next       = 1'b0;
            row_addr_next = '0;
            row_y_next    = '0;
            row_z_next    = '0;
            nb_dy_next    = '0;
            nb_dz_next    = '0;
        end

        // Step to the next row of the grid.
        if ((state_reg == ca3d_pkg::ST_CLEAR) || (state_reg == ca3d_pkg::ST_SWEEP) ||
            (state_reg == ca3d_pkg::ST_STEP_WR)) begin
            if (last_row) begin
                row_addr_next = '0;
                row_y_next    = '0;
                row_z_next    = '0;
            end else begin
                row_addr_next = row_addr_reg + 1'b1;
                if (row_y_reg == CW'(Y_SIZE - 1)) begin
                    row_y_next = '0;
                    row_z_next = row_z_reg + 1'b1;
                end else begin
                    row_y_next = row_y_reg + 1'b1;
                end
            end
        end

        // Walk the nine neighbour rows.
        if (state_reg == ca3d_pkg::ST_STEP_RD) begin
            if (nb_dy_reg == 2'd2) begin
                nb_dy_next = '0;
                nb_dz_next = nb_dz_reg + 1'b1;
            end else begin
                nb_dy_next = nb_dy_reg + 1'b1;
            end
        end
        if (state_reg == ca3d_pkg::ST_STEP_WR) begin
            nb_dy_next = '0;
            nb_dz_next = '0;
            if (last_row) begin
                bank_next = !bank_reg;
            end
        end

        if ((state_reg == ca3d_pkg::ST_CELL_WR) && (act_reg == ca3d_pkg::ACT_READ)) begin
            rv_next = rd_data[x_idx];
        end

        // Result register.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == ca3d_pkg::ST_DONE) && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = {6'd0, (act_reg == ca3d_pkg::ACT_READ), rv_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ca3d_pkg::ST_CLEAR;
            row_addr_reg <= '0;
            row_y_reg    <= '0;
            row_z_reg    <= '0;
            nb_dy_reg    <= '0;
            nb_dz_reg    <= '0;
            pend_acc_reg <= 1'b0;
            pend_ctr_reg <= 1'b0;
            bank_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_addr_reg <= row_addr_next;
            row_y_reg    <= row_y_next;
            row_z_reg    <= row_z_next;
            nb_dy_reg    <= nb_dy_next;
            nb_dz_reg    <= nb_dz_next;
            pend_acc_reg <= pend_acc_next;
            pend_ctr_reg <= pend_ctr_next;
            bank_reg     <= bank_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pz_reg     <= pz_next;
        wv_reg     <= wv_next;
        rv_reg     <= rv_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/cellular_automaton_3d.sv
// A write or read of a cell inside the grid passes through ST_CELL_RD, ST_CELL_WR and
// ST_DONE; fill and border seeding sweep every row once; a generation walks all rows; a
// cell outside the grid or an unused action code goes straight to ST_DONE, where stalls on m_tready hold it.
// Throughput: one transaction at a time; a generation handles each row of X cells with
// nine neighbour row reads through the single memory read port, then a wait and a write.
// Reset: synchronous, active low; a clearing pass over every row then zeroes both banks.
`timescale 1ns / 1ps
`default_nettype none

module cellular_automaton_3d #(
    parameter int X_SIZE = ca3d_pkg::X_SIZE_DEF,
    parameter int Y_SIZE = ca3d_pkg::Y_SIZE_DEF,
    parameter int Z_SIZE = ca3d_pkg::Z_SIZE_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // action[2:0], pos_x[8:3], pos_y[13:9], pos_z[18:14], write_value[19], zero
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ca3d_pkg::IN_TDATA_W-1:0]     s_tdata,
    // read_value[0], was_read[1], zero
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [ca3d_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ca3d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ca3d_pkg::CNT_W-1:0]          cfg_data
);

    localparam int ROWS = Y_SIZE * Z_SIZE;

    ca3d_pkg::rule_cfg_t cfg_reg;
    ca3d_pkg::mem_ctl_t  mem_ctl;
    ca3d_pkg::lane_ctl_t lane_ctl;
    logic [X_SIZE-1:0]   wr_data;
    logic [X_SIZE-1:0]   rd_data;
    logic [X_SIZE-1:0]   row_next;

    // Rule register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.birth   <= ca3d_pkg::BIRTH_RST;
            cfg_reg.surv_lo <= ca3d_pkg::SURV_LO_RST;
            cfg_reg.surv_hi <= ca3d_pkg::SURV_HI_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ca3d_pkg::CFG_BIRTH:   cfg_reg.birth   <= cfg_data;
                ca3d_pkg::CFG_SURV_LO: cfg_reg.surv_lo <= cfg_data;
                ca3d_pkg::CFG_SURV_HI: cfg_reg.surv_hi <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ca3d_ctrl #(
        .X_SIZE (X_SIZE),
        .Y_SIZE (Y_SIZE),
        .Z_SIZE (Z_SIZE)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .mem_ctl  (mem_ctl),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .lane_ctl (lane_ctl),
        .row_next (row_next)
    );

    ca3d_grid_mem #(
        .ROWS     (ROWS),
        .ROW_BITS (X_SIZE)
    ) u_grid_mem (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    ca3d_lanes #(
        .X_SIZE (X_SIZE)
    ) u_lanes (
        .aclk    (aclk),
        .ctl     (lane_ctl),
        .cfg     (cfg_reg),
        .row_in  (rd_data),
        .row_out (row_next)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ca3d_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "cellular_automaton_3d_assert.svh"

// Port-level checks on the result channel.
module ca3d_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [ca3d_pkg::OUT_TDATA_W-1:0] m_tdata
);

    `CA3D_ASSERT_NEXT(a_valid_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `CA3D_ASSERT_NEXT(a_data_held, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `CA3D_ASSERT_SAME(a_value_on_read, aclk, aresetn, m_tvalid && !m_tdata[1], !m_tdata[0], "read value set on a non-read result")
    `CA3D_ASSERT_SAME(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:2] == 6'd0, "result padding not zero")

endmodule

bind cellular_automaton_3d ca3d_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/cellular_automaton_3d_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and rule-register ports of the automaton. It
// keeps its own copy of both grid banks and the rules, predicts the answer to
// every accepted command and compares each returned answer in order.
module cellular_automaton_3d_checker
    import ca3d_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CNT_W-1:0]       cfg_data,
    output int                     failures,
    output int                     pending
);

    localparam int XS = X_SIZE_DEF;
    localparam int YS = Y_SIZE_DEF;
    localparam int ZS = Z_SIZE_DEF;
    localparam int CELLS = XS * YS * ZS;

    typedef struct {
        bit read_value;
        bit was_read;
    } cell_answer_t;

    bit           grid [2][CELLS];
    bit           live_bank;
    rule_cfg_t    rules;
    cell_answer_t answers_due [$];
    int           answers_seen;

    function automatic int cell_at(int x, int y, int z);
        return x + XS * (y + YS * z);
    endfunction

    // Live cells among the 26 neighbours; cells beyond the faces count as dead.
    function automatic int live_around(int x, int y, int z);
        int n;
        n = 0;
        for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++) begin
                    if (dx == 0 && dy == 0 && dz == 0) continue;
                    if (x + dx < 0 || x + dx >= XS || y + dy < 0 || y + dy >= YS ||
                        z + dz < 0 || z + dz >= ZS) continue;
                    n += int'(grid[live_bank][cell_at(x + dx, y + dy, z + dz)]);
                end
        return n;
    endfunction

    // One generation is built in the idle bank, after which the banks swap.
    task automatic advance_generation();
        bit nb;
        int n;
        int i;
        nb = !live_bank;
        for (int z = 0; z < ZS; z++)
            for (int y = 0; y < YS; y++)
                for (int x = 0; x < XS; x++) begin
                    i = cell_at(x, y, z);
                    n = live_around(x, y, z);
                    if (grid[live_bank][i])
                        grid[nb][i] = (n >= rules.surv_lo && n <= rules.surv_hi);
                    else
                        grid[nb][i] = (n == rules.birth);
                end
        live_bank = nb;
    endtask

    task automatic report(string what, int got, int want);
        $display("%0t: mismatch in answer %0d: %s got %0d, expected %0d",
                 $realtime, answers_seen, what, got, want);
        failures++;
    endtask

    assign pending = answers_due.size();

    initial failures = 0;

    always @(posedge aclk) begin
        cell_answer_t ans;
        action_t      act;
        int           x, y, z;
        bit           wv;
        if (!aresetn) begin
            foreach (grid[b, i]) grid[b][i] = 1'b0;
            live_bank = 1'b0;
            rules = '{birth: BIRTH_RST, surv_lo: SURV_LO_RST, surv_hi: SURV_HI_RST};
            answers_due.delete();
            answers_seen = 0;
        end else begin
            // Rule register writes.
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BIRTH:   rules.birth   = cfg_data;
                    CFG_SURV_LO: rules.surv_lo = cfg_data;
                    CFG_SURV_HI: rules.surv_hi = cfg_data;
                    default: ;
                endcase
            end

            // Compare a returned transaction with the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report("answers outstanding", 1, 0);
                end else begin
                    ans = answers_due.pop_front();
                    if (m_tdata[0] !== ans.read_value)
                        report("read_value", m_tdata[0], ans.read_value);
                    if (m_tdata[1] !== ans.was_read)
                        report("was_read", m_tdata[1], ans.was_read);
                end
                answers_seen++;
            end

            // Predict the answer to an accepted command.
            if (s_tvalid && s_tready) begin
                act = action_t'(s_tdata[2:0]);
                x   = int'(s_tdata[8:3]);
                y   = int'(s_tdata[13:9]);
                z   = int'(s_tdata[18:14]);
                wv  = s_tdata[19];
                ans = '{read_value: 1'b0, was_read: 1'b0};
                case (act)
                    ACT_WRITE: grid[live_bank][cell_at(x, y, z)] = wv;
                    ACT_READ: begin
                        ans.read_value = grid[live_bank][cell_at(x, y, z)];
                        ans.was_read   = 1'b1;
                    end
                    ACT_FILL:
                        for (int i = 0; i < CELLS; i++) grid[live_bank][i] = wv;
                    ACT_SEED:
                        for (int k = 0; k < ZS; k++)
                            for (int j = 0; j < YS; j++)
                                for (int i = 0; i < XS; i++)
                                    grid[live_bank][cell_at(i, j, k)] =
                                        (i == 0 || i == XS - 1 || j == 0 || j == YS - 1 ||
                                         k == 0 || k == ZS - 1);
                    ACT_STEP: advance_generation();
                    default: ;
                endcase
                answers_due.push_back(ans);
            end
        end
    end

endmodule

>>> bench/cellular_automaton_3d_tb.sv
`timescale 1ns / 1ps

// Drives commands and rule settings into the automaton, applies back-pressure
// on the answer channel and gives the verdict from the checker's count.
module cellular_automaton_3d_tb;
    import ca3d_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CNT_W-1:0]       cfg_data;
    int                     failures;
    int                     pending;
    int                     cycles;
    int                     sent_by_action [8];
    bit                     gaps_on;

    cellular_automaton_3d dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cellular_automaton_3d_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if (!gaps_on) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Answer-side stalls.
    initial begin
        int hold;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            hold = gap_len();
            if (hold > 0) begin
                m_tready = 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_cmd(action_t act, int x, int y, int z, bit wv);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, wv, z[4:0], y[4:0], x[5:0], act};
        do @(posedge aclk); while (!s_tready);
        sent_by_action[act]++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_rules(int birth, int lo, int hi);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = CFG_BIRTH;
        cfg_data  = CNT_W'(birth);
        @(negedge aclk);
        cfg_index = CFG_SURV_LO;
        cfg_data  = CNT_W'(lo);
        @(negedge aclk);
        cfg_index = CFG_SURV_HI;
        cfg_data  = CNT_W'(hi);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic int near(int c, int lim);
        int v;
        v = c + $urandom_range(0, 4) - 2;
        return v < 0 ? 0 : (v > lim ? lim : v);
    endfunction

    // An optional fill or seed, a cluster of writes around a centre, some generations, then probing reads and noise.
    task automatic cluster_run();
        int cx, cy, cz;
        cx = $urandom_range(0, 63);
        cy = $urandom_range(0, 31);
        cz = $urandom_range(0, 31);
        case ($urandom_range(0, 3))
            0: send_cmd(ACT_FILL, $urandom_range(0, 63), $urandom_range(0, 31),
                        $urandom_range(0, 31), 1'b0);
            1: send_cmd(ACT_FILL, 0, 0, 0, 1'b1);
            2: send_cmd(ACT_SEED, $urandom_range(0, 63), 0, 0, $urandom_range(0, 1));
            default: ;
        endcase
        repeat ($urandom_range(3, 6))
            send_cmd(ACT_WRITE, near(cx, 63), near(cy, 31), near(cz, 31),
                     $urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 2)) send_cmd(ACT_STEP, 0, 0, 0, 1'b0);
        repeat ($urandom_range(2, 4))
            send_cmd(ACT_READ, near(cx, 63), near(cy, 31), near(cz, 31), 1'b0);
        // Noise: unused codes and reads anywhere.
        repeat ($urandom_range(0, 2))
            send_cmd(action_t'($urandom_range(5, 7)), $urandom_range(0, 63),
                     $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
        send_cmd(ACT_READ, $urandom_range(0, 63), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 1));
    endtask

    initial begin
        int rule_sets [6][3];
        rule_sets = '{'{9, 6, 9}, '{0, 0, 0}, '{26, 26, 26}, '{31, 31, 31},
                      '{4, 9, 3}, '{3, 2, 5}};
        foreach (sent_by_action[i]) sent_by_action[i] = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_BIRTH;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: corners, unused codes, filled and seeded generations.
        send_cmd(ACT_READ, 0, 0, 0, 1'b0);
        send_cmd(ACT_WRITE, 0, 0, 0, 1'b1);
        send_cmd(ACT_WRITE, 63, 31, 31, 1'b1);
        send_cmd(ACT_READ, 0, 0, 0, 1'b0);
        send_cmd(ACT_READ, 63, 31, 31, 1'b1);
        send_cmd(action_t'(3'd5), 63, 31, 31, 1'b1);
        send_cmd(action_t'(3'd6), 1, 1, 1, 1'b0);
        send_cmd(action_t'(3'd7), 42, 21, 10, 1'b1);
        send_cmd(ACT_FILL, 0, 0, 0, 1'b1);
        send_cmd(ACT_READ, 32, 16, 16, 1'b0);
        send_cmd(ACT_STEP, 0, 0, 0, 1'b0);
        send_cmd(ACT_READ, 0, 0, 0, 1'b0);
        send_cmd(ACT_READ, 63, 0, 31, 1'b0);
        send_cmd(ACT_READ, 5, 5, 5, 1'b0);
        send_cmd(ACT_SEED, 0, 0, 0, 1'b0);
        send_cmd(ACT_READ, 0, 7, 9, 1'b0);
        send_cmd(ACT_READ, 7, 7, 9, 1'b0);
        send_cmd(ACT_STEP, 0, 0, 0, 1'b0);
        send_cmd(ACT_READ, 1, 1, 1, 1'b0);
        send_cmd(ACT_READ, 0, 15, 15, 1'b0);
        send_cmd(ACT_FILL, 0, 0, 0, 1'b0);
        send_cmd(ACT_READ, 63, 31, 31, 1'b0);

        // Random phases, each under its own rules, with and without idling.
        foreach (rule_sets[p]) begin
            wait_drained();
            set_rules(rule_sets[p][0], rule_sets[p][1], rule_sets[p][2]);
            gaps_on = (p != 2);
            cluster_run();
        end
        wait_drained();
        set_rules($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
        cluster_run();

        wait_drained();
        repeat (50) @(posedge aclk);
        $display("Commands: %0d writes, %0d reads, %0d fills, %0d seeds, %0d generations,",
                 sent_by_action[ACT_WRITE], sent_by_action[ACT_READ],
                 sent_by_action[ACT_FILL], sent_by_action[ACT_SEED],
                 sent_by_action[ACT_STEP]);
        $display("%0d unused codes, over seven rule settings; %0d mismatches.",
                 sent_by_action[5] + sent_by_action[6] + sent_by_action[7], failures);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
